// File: hdl/detector_pad_hit_lookup_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the pad hit lookup
// Implication checks on the clock, switched off by NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef DETECTOR_PAD_HIT_LOOKUP_DEFINES_SVH
`define DETECTOR_PAD_HIT_LOOKUP_DEFINES_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define DPHL_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
	else $error("same-cycle implication failed");
// next-cycle implication
`define DPHL_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
	else $error("next-cycle implication failed");
`else
`define DPHL_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define DPHL_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// File: hdl/dphl_pkg.sv
// ----------------------------------------------------------------------------
// dphl_pkg
// Types, codes and defaults shared by the pad hit lookup modules.
// ----------------------------------------------------------------------------
`default_nettype none
package dphl_pkg;

	// default geometry
	localparam int MAX_COLUMNS_DEF = 128;
	localparam int MAX_ROWS_DEF    = 128;
	localparam int CORNERS_DEF     = 4;
	localparam int COORD_BITS      = 16;
	localparam int PN_W            = 14;   // pad number width

	// item queue between front and back
	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// commands
	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	// register indexes
	localparam logic [2:0] REG_COLUMNS = 3'd0;
	localparam logic [2:0] REG_ROWS    = 3'd1;
	localparam logic [2:0] REG_REF_ROW = 3'd2;
	localparam logic [2:0] REG_SPLIT_N = 3'd3;
	localparam logic [2:0] REG_SPLIT_X = 3'd4;

	typedef struct packed {
		logic                          command;
		logic [6:0]                    pad_column;
		logic [6:0]                    pad_row;
		logic [1:0]                    corner_index;
		logic signed [COORD_BITS-1:0]  coord_x;
		logic signed [COORD_BITS-1:0]  coord_y;
		logic                          inside_side;
		logic                          pad_enable;
	} in_item_t;

	typedef struct packed {
		logic            hit_found;
		logic [6:0]      hit_column;
		logic [6:0]      hit_row;
		logic [PN_W-1:0] hit_pad_number;
	} result_t;

	typedef struct packed {
		logic [7:0]                   columns_in_use;
		logic [7:0]                   rows_in_use;
		logic [6:0]                   reference_row;
		logic [PN_W-1:0]              split_pad_number;
		logic signed [COORD_BITS-1:0] split_x;
	} cfg_t;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] x;
		logic signed [COORD_BITS-1:0] y;
		logic                         flag;
	} corner_t;

	// queue head seen by the back end
	typedef struct packed {
		logic     valid;
		in_item_t item;
	} q_head_t;

	// back end status seen by the front end
	typedef struct packed {
		logic pop;
		logic clearing;
	} bk_stat_t;

endpackage
`default_nettype wire

// File: hdl/dphl_front.sv
// ----------------------------------------------------------------------------
// dphl_front
// Accepts items, drops out-of-range loads and queues the rest for the back end.
// ----------------------------------------------------------------------------
`default_nettype none
module dphl_front #(
	parameter int MAX_COLUMNS = dphl_pkg::MAX_COLUMNS_DEF,
	parameter int MAX_ROWS    = dphl_pkg::MAX_ROWS_DEF,
	parameter int CORNERS     = dphl_pkg::CORNERS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire dphl_pkg::in_item_t item,
	input  wire dphl_pkg::bk_stat_t stat,
	output dphl_pkg::q_head_t       head
);

	dphl_pkg::in_item_t              ent_q [dphl_pkg::QDEPTH];
	logic [dphl_pkg::QPTR_W-1:0]     wr_q, rd_q;
	logic [dphl_pkg::QCNT_W-1:0]     count_q;
	logic                            accept, keep, push;

	// classify: queries always pass, loads only when in range
	assign busy   = (count_q == dphl_pkg::QCNT_W'(dphl_pkg::QDEPTH)) | stat.clearing;
	assign accept = start & ~busy;
	assign keep   = (item.command == dphl_pkg::CMD_QUERY) ||
		((32'(item.corner_index) < CORNERS) && (32'(item.pad_column) < MAX_COLUMNS) &&
		 (32'(item.pad_row) < MAX_ROWS));
	assign push   = accept & keep;

	assign head.valid = (count_q != '0);
	assign head.item  = ent_q[rd_q];

	// queue payload
	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_q] <= item;
		end
	end

	// queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + dphl_pkg::QPTR_W'(1);
			end
			if (stat.pop) begin
				rd_q <= rd_q + dphl_pkg::QPTR_W'(1);
			end
			count_q <= count_q + dphl_pkg::QCNT_W'(push) - dphl_pkg::QCNT_W'(stat.pop);
		end
	end

endmodule
`default_nettype wire

// File: hdl/dphl_back.sv
// ----------------------------------------------------------------------------
// dphl_back
// Pad tables and the two-stage search sequencer with its edge test unit.
// ----------------------------------------------------------------------------
`default_nettype none
module dphl_back #(
	parameter int MAX_COLUMNS = dphl_pkg::MAX_COLUMNS_DEF,
	parameter int MAX_ROWS    = dphl_pkg::MAX_ROWS_DEF,
	parameter int CORNERS     = dphl_pkg::CORNERS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire dphl_pkg::cfg_t    cfg,
	input  wire dphl_pkg::q_head_t head,
	output dphl_pkg::bk_stat_t     stat,
	output logic                   done,
	output dphl_pkg::result_t      result
);

	localparam int SLOTS  = MAX_COLUMNS * MAX_ROWS;
	localparam int SLOT_W = $clog2(SLOTS);
	localparam int CADR_W = $clog2(SLOTS * CORNERS);
	localparam int CW     = $clog2(MAX_COLUMNS + 1);
	localparam int RW     = $clog2(MAX_ROWS + 1);
	localparam int KW     = $clog2(CORNERS + 1);
	localparam int AW0    = $clog2(128 * MAX_COLUMNS + 1);
	localparam int AW     = (AW0 > dphl_pkg::PN_W) ? AW0 : dphl_pkg::PN_W;
	localparam int PN_W   = dphl_pkg::PN_W;
	localparam int DC_W   = $clog2(PN_W);
	localparam int CB     = dphl_pkg::COORD_BITS;
	localparam int PW     = 2 * CB + 2;

	localparam logic [3:0] ST_CLR  = 4'd0;
	localparam logic [3:0] ST_IDLE = 4'd1;
	localparam logic [3:0] ST_DIV  = 4'd2;
	localparam logic [3:0] ST_SCAN = 4'd3;
	localparam logic [3:0] ST_C0   = 4'd4;
	localparam logic [3:0] ST_EDGE = 4'd5;
	localparam logic [3:0] ST_CMP  = 4'd6;
	localparam logic [3:0] ST_ROW  = 4'd7;
	localparam logic [3:0] ST_NUM  = 4'd8;

	// tables
	dphl_pkg::corner_t corner_mem [SLOTS*CORNERS];
	logic              act_mem    [SLOTS];
	dphl_pkg::corner_t cm_rdata;
	logic              am_rdata;
	logic [CADR_W-1:0] cm_raddr, cm_waddr;
	logic [SLOT_W-1:0] am_raddr, am_waddr;
	logic              cm_we, am_we, am_wdata;
	dphl_pkg::corner_t cm_wdata;

	// control
	logic [3:0]        state_q;
	logic [SLOT_W-1:0] clr_q, slot_q, scan_slot, row_slot, load_slot;
	logic [CW-1:0]     cols_eff, c_q, found_col_q, rem_n;
	logic [RW-1:0]     rows_eff, j_q;
	logic [AW-1:0]     addr_q, stop_q, ref_base;
	logic [PN_W-1:0]   r_q, dvd_q, quo_q;
	logic [DC_W-1:0]   div_cnt_q;
	logic [CW:0]       div_t;
	logic              div_ge, stage2_q, only_x_q, row_ok, pad_fail, pad_pass;
	logic [KW-1:0]     k_q, k_rd;
	logic signed [CB-1:0] qx_q, qy_q;
	logic              is_load, is_query, lo_half;

	// edge test
	dphl_pkg::corner_t first_q, prev_q, cur, cur_hold_q;
	logic signed [CB:0]   dx, dy, ex, ey;
	logic signed [PW-1:0] p1_q, p2_q;
	logic              vert_q, hor_q, vh_out_q, dxneg_q, flag_q, edge_out, s_neg, s_pos;
	logic              vert_n, vh_out_n;

	// effective grid size
	always_comb begin
		if (cfg.columns_in_use == '0) begin
			cols_eff = CW'(1);
		end else if (32'(cfg.columns_in_use) > MAX_COLUMNS) begin
			cols_eff = CW'(MAX_COLUMNS);
		end else begin
			cols_eff = CW'(cfg.columns_in_use);
		end
		if (cfg.rows_in_use == '0) begin
			rows_eff = RW'(1);
		end else if (32'(cfg.rows_in_use) > MAX_ROWS) begin
			rows_eff = RW'(MAX_ROWS);
		end else begin
			rows_eff = RW'(cfg.rows_in_use);
		end
	end

	// query setup and divider step
	assign ref_base = AW'(cfg.reference_row) * AW'(cols_eff);
	assign lo_half  = head.item.coord_x < cfg.split_x;
	assign div_t    = {c_q, dvd_q[PN_W-1]};
	assign div_ge   = div_t >= {1'b0, cols_eff};
	assign rem_n    = div_ge ? CW'(div_t - {1'b0, cols_eff}) : div_t[CW-1:0];

	// slot addresses
	assign row_ok    = 32'(r_q) < 32'(rows_eff);
	assign scan_slot = SLOT_W'(r_q) * SLOT_W'(MAX_COLUMNS) + SLOT_W'(c_q);
	assign row_slot  = SLOT_W'(j_q) * SLOT_W'(MAX_COLUMNS) + SLOT_W'(found_col_q);
	assign load_slot = SLOT_W'(head.item.pad_row) * SLOT_W'(MAX_COLUMNS) +
		SLOT_W'(head.item.pad_column);
	assign is_query  = head.valid && (head.item.command == dphl_pkg::CMD_QUERY);
	assign is_load   = head.valid && (head.item.command == dphl_pkg::CMD_LOAD);

	assign stat.clearing = (state_q == ST_CLR);
	assign stat.pop      = (state_q == ST_IDLE) && head.valid;

	// table port control
	always_comb begin
		k_rd = '0;
		am_raddr = slot_q;
		case (state_q)
			ST_SCAN: am_raddr = scan_slot;
			ST_ROW:  am_raddr = row_slot;
			ST_C0:   k_rd = KW'(1);
			ST_CMP:  k_rd = (32'(k_q) + 1 < CORNERS) ? k_q + KW'(1) : '0;
			default: k_rd = '0;
		endcase
		cm_raddr = CADR_W'(am_raddr) * CADR_W'(CORNERS) + CADR_W'(k_rd);
		cm_we    = stat.pop && is_load;
		cm_waddr = CADR_W'(load_slot) * CADR_W'(CORNERS) + CADR_W'(head.item.corner_index);
		cm_wdata.x    = head.item.coord_x;
		cm_wdata.y    = head.item.coord_y;
		cm_wdata.flag = head.item.inside_side;
		am_we    = cm_we || stat.clearing;
		am_waddr = stat.clearing ? clr_q : load_slot;
		am_wdata = stat.clearing ? 1'b0 : head.item.pad_enable;
	end

	always_ff @(posedge clk) begin
		if (cm_we) begin
			corner_mem[cm_waddr] <= cm_wdata;
		end
		cm_rdata <= corner_mem[cm_raddr];
	end

	always_ff @(posedge clk) begin
		if (am_we) begin
			act_mem[am_waddr] <= am_wdata;
		end
		am_rdata <= act_mem[am_raddr];
	end

	// edge operands: current corner wraps to the first one at the end
	always_comb begin
		cur = (32'(k_q) == CORNERS) ? first_q : cm_rdata;
		dx  = $signed({cur.x[CB-1], cur.x}) - $signed({prev_q.x[CB-1], prev_q.x});
		dy  = $signed({cur.y[CB-1], cur.y}) - $signed({prev_q.y[CB-1], prev_q.y});
		ex  = $signed({qx_q[CB-1], qx_q}) - $signed({prev_q.x[CB-1], prev_q.x});
		ey  = $signed({qy_q[CB-1], qy_q}) - $signed({prev_q.y[CB-1], prev_q.y});
		vert_n = (cur.x == prev_q.x);
		if (vert_n) begin
			vh_out_n = prev_q.flag ? (qx_q < prev_q.x) : (qx_q > prev_q.x);
		end else begin
			vh_out_n = prev_q.flag ? (qy_q < prev_q.y) : (qy_q > prev_q.y);
		end
	end

	// edge decision on registered products
	always_comb begin
		s_neg = dxneg_q ? (p1_q > p2_q) : (p1_q < p2_q);
		s_pos = dxneg_q ? (p1_q < p2_q) : (p1_q > p2_q);
		if (vert_q) begin
			edge_out = vh_out_q;
		end else if (only_x_q) begin
			edge_out = 1'b0;
		end else if (hor_q) begin
			edge_out = vh_out_q;
		end else begin
			edge_out = flag_q ? s_neg : s_pos;
		end
		pad_fail = ((state_q == ST_C0) && !am_rdata) || ((state_q == ST_CMP) && edge_out);
		pad_pass = (state_q == ST_CMP) && !edge_out && (32'(k_q) == CORNERS);
	end

	// edge unit payload
	always_ff @(posedge clk) begin
		if (state_q == ST_EDGE) begin
			p1_q     <= PW'(ey) * PW'(dx);
			p2_q     <= PW'(dy) * PW'(ex);
			vert_q   <= vert_n;
			hor_q    <= (cur.y == prev_q.y);
			vh_out_q <= vh_out_n;
			dxneg_q  <= dx < 0;
			flag_q   <= prev_q.flag;
			cur_hold_q <= cur;
		end
	end

	// search sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
			clr_q   <= '0;
			done    <= 1'b0;
		end else begin
			done <= 1'b0;
			if (pad_fail) begin
				if (!stage2_q) begin
					addr_q  <= addr_q + AW'(1);
					if (c_q == cols_eff - CW'(1)) begin
						c_q <= '0;
						r_q <= r_q + PN_W'(1);
					end else begin
						c_q <= c_q + CW'(1);
					end
					state_q <= ST_SCAN;
				end else if (j_q == rows_eff - RW'(1)) begin
					done    <= 1'b1;
					result  <= '0;
					state_q <= ST_IDLE;
				end else begin
					j_q     <= j_q + RW'(1);
					state_q <= ST_ROW;
				end
			end else if (pad_pass) begin
				if (!stage2_q) begin
					found_col_q <= c_q;
					j_q         <= '0;
					stage2_q    <= 1'b1;
					state_q     <= ST_ROW;
				end else begin
					state_q <= ST_NUM;
				end
			end else begin
				case (state_q)
					ST_CLR: begin
						clr_q <= clr_q + SLOT_W'(1);
						if (32'(clr_q) == SLOTS - 1) begin
							state_q <= ST_IDLE;
						end
					end
					ST_IDLE: begin
						if (is_query) begin
							qx_q     <= head.item.coord_x;
							qy_q     <= head.item.coord_y;
							stage2_q <= 1'b0;
							if (lo_half) begin
								r_q     <= PN_W'(cfg.reference_row);
								c_q     <= '0;
								addr_q  <= ref_base;
								stop_q  <= AW'(cfg.split_pad_number);
								state_q <= ST_SCAN;
							end else begin
								dvd_q     <= cfg.split_pad_number;
								quo_q     <= '0;
								c_q       <= '0;
								div_cnt_q <= '0;
								addr_q    <= AW'(cfg.split_pad_number);
								stop_q    <= ref_base + AW'(cols_eff);
								state_q   <= ST_DIV;
							end
						end
					end
					ST_DIV: begin
						// c_q holds the partial remainder during division
						c_q       <= rem_n;
						quo_q     <= {quo_q[PN_W-2:0], div_ge};
						dvd_q     <= {dvd_q[PN_W-2:0], 1'b0};
						div_cnt_q <= div_cnt_q + DC_W'(1);
						if (32'(div_cnt_q) == PN_W - 1) begin
							r_q     <= {quo_q[PN_W-2:0], div_ge};
							state_q <= ST_SCAN;
						end
					end
					ST_SCAN: begin
						if (addr_q >= stop_q) begin
							done    <= 1'b1;
							result  <= '0;
							state_q <= ST_IDLE;
						end else if (!row_ok) begin
							addr_q <= addr_q + AW'(1);
							if (c_q == cols_eff - CW'(1)) begin
								c_q <= '0;
								r_q <= r_q + PN_W'(1);
							end else begin
								c_q <= c_q + CW'(1);
							end
						end else begin
							slot_q   <= scan_slot;
							only_x_q <= 1'b1;
							state_q  <= ST_C0;
						end
					end
					ST_ROW: begin
						slot_q   <= row_slot;
						only_x_q <= 1'b0;
						state_q  <= ST_C0;
					end
					ST_C0: begin
						first_q <= cm_rdata;
						prev_q  <= cm_rdata;
						k_q     <= KW'(1);
						state_q <= ST_EDGE;
					end
					ST_EDGE: begin
						state_q <= ST_CMP;
					end
					ST_CMP: begin
						prev_q  <= cur_hold_q;
						k_q     <= k_q + KW'(1);
						state_q <= ST_EDGE;
					end
					ST_NUM: begin
						done                  <= 1'b1;
						result.hit_found      <= 1'b1;
						result.hit_column     <= 7'(found_col_q);
						result.hit_row        <= 7'(j_q);
						result.hit_pad_number <= PN_W'(found_col_q) +
							PN_W'(j_q) * PN_W'(cols_eff);
						state_q               <= ST_IDLE;
					end
					default: state_q <= ST_IDLE;
				endcase
			end
		end
	end

endmodule
`default_nettype wire

// File: hdl/detector_pad_hit_lookup.sv
// ----------------------------------------------------------------------------
// detector_pad_hit_lookup
// Finds the detector pad that contains a hit position; loads pad corners.
// ----------------------------------------------------------------------------
//  channel   handshake              payload
//  input     start / busy           item   (in_item_t)
//  result    done strobe            result (result_t), one cycle, no stall
//  config    APB psel/penable/...   pwdata, five registers at 4*index
//
// A load is written to the tables when the back end pops it. A query is set
// up from idle, through the pad number divider when the right half is
// scanned; then pads outside the rows are skipped, inactive pads fail on
// their first corner read and active pads run the edge test per corner,
// then the same per row of the found column. The per-corner edge test unit
// registers its cross products before each decision. After reset the active-bit
// table is cleared, one pad a cycle, with busy high. Results cannot be held off.
`default_nettype none
`include "detector_pad_hit_lookup_defines.svh"
module detector_pad_hit_lookup #(
	parameter int MAX_COLUMNS = dphl_pkg::MAX_COLUMNS_DEF,
	parameter int MAX_ROWS    = dphl_pkg::MAX_ROWS_DEF,
	parameter int CORNERS     = dphl_pkg::CORNERS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire dphl_pkg::in_item_t item,
	output logic                    done,
	output dphl_pkg::result_t       result,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [4:0]         paddr,
	input  wire logic [31:0]        pwdata,
	output logic [31:0]             prdata,
	output logic                    pready
);

	dphl_pkg::cfg_t     cfg_q;
	dphl_pkg::q_head_t  head;
	dphl_pkg::bk_stat_t stat;
	logic               wr_en;
	logic [2:0]         reg_idx;

	// register file
	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite & pready;
	assign reg_idx = paddr[4:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.columns_in_use   <= 8'd128;
			cfg_q.rows_in_use      <= 8'd128;
			cfg_q.reference_row    <= '0;
			cfg_q.split_pad_number <= '0;
			cfg_q.split_x          <= '0;
		end else if (wr_en) begin
			case (reg_idx)
				dphl_pkg::REG_COLUMNS: cfg_q.columns_in_use   <= pwdata[7:0];
				dphl_pkg::REG_ROWS:    cfg_q.rows_in_use      <= pwdata[7:0];
				dphl_pkg::REG_REF_ROW: cfg_q.reference_row    <= pwdata[6:0];
				dphl_pkg::REG_SPLIT_N: cfg_q.split_pad_number <= pwdata[13:0];
				dphl_pkg::REG_SPLIT_X: cfg_q.split_x          <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// register read back
	always_comb begin
		case (reg_idx)
			dphl_pkg::REG_COLUMNS: prdata = 32'(cfg_q.columns_in_use);
			dphl_pkg::REG_ROWS:    prdata = 32'(cfg_q.rows_in_use);
			dphl_pkg::REG_REF_ROW: prdata = 32'(cfg_q.reference_row);
			dphl_pkg::REG_SPLIT_N: prdata = 32'(cfg_q.split_pad_number);
			dphl_pkg::REG_SPLIT_X: prdata = {16'd0, cfg_q.split_x};
			default:               prdata = '0;
		endcase
	end

	dphl_front #(
		.MAX_COLUMNS(MAX_COLUMNS),
		.MAX_ROWS   (MAX_ROWS),
		.CORNERS    (CORNERS)
	) u_front (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.item  (item),
		.stat  (stat),
		.head  (head)
	);

	dphl_back #(
		.MAX_COLUMNS(MAX_COLUMNS),
		.MAX_ROWS   (MAX_ROWS),
		.CORNERS    (CORNERS)
	) u_back (
		.clk   (clk),
		.arst_n(arst_n),
		.cfg   (cfg_q),
		.head  (head),
		.stat  (stat),
		.done  (done),
		.result(result)
	);

	// checks
	`DPHL_ASSERT_NEXT(a_one_result, clk, arst_n, done, !done)
	`DPHL_ASSERT_IMPL(a_miss_zero, clk, arst_n, done && !result.hit_found, result.hit_column == '0 && result.hit_row == '0 && result.hit_pad_number == '0)
	`DPHL_ASSERT_NEXT(a_queued, clk, arst_n, start && !busy && (item.command == dphl_pkg::CMD_QUERY), head.valid)
	`DPHL_ASSERT_IMPL(a_no_pop_clr, clk, arst_n, stat.clearing, !stat.pop)

endmodule
`default_nettype wire

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: pad hit lookup testbench
// Loads pad corners and sends position queries through the start/busy port.
// A scoreboard predicts each lookup and checks the done/result strobe. The
// grid registers change between phases over the APB port, only while idle.
// ----------------------------------------------------------------------------

// pad table mirror and lookup prediction
class pad_scoreboard;
	dphl_pkg::corner_t corner_tab[65536];
	bit         active[16384];
	bit [3:0]   written[16384];
	dphl_pkg::result_t lookups_due[$];
	logic [7:0] cols_reg = 8'd128;
	logic [7:0] rows_reg = 8'd128;
	logic [6:0] ref_row = 7'd0;
	logic [dphl_pkg::PN_W-1:0] split_num = '0;
	logic signed [dphl_pkg::COORD_BITS-1:0] split_x = '0;
	int errors, loads, queries, hits;

	function void set_reg(logic [2:0] idx, logic [31:0] val);
		case (idx)
			dphl_pkg::REG_COLUMNS: cols_reg = val[7:0];
			dphl_pkg::REG_ROWS:    rows_reg = val[7:0];
			dphl_pkg::REG_REF_ROW: ref_row = val[6:0];
			dphl_pkg::REG_SPLIT_N: split_num = val[dphl_pkg::PN_W-1:0];
			dphl_pkg::REG_SPLIT_X: split_x = val[dphl_pkg::COORD_BITS-1:0];
			default: ;
		endcase
	endfunction

	function int eff_cols();
		if (cols_reg == 0) return 1;
		return (cols_reg > 128) ? 128 : int'(cols_reg);
	endfunction

	function int eff_rows();
		if (rows_reg == 0) return 1;
		return (rows_reg > 128) ? 128 : int'(rows_reg);
	endfunction

	// true if the point is outside the pad; only vertical edges when only_x
	function bit pad_outside(int slot, longint x, longint y, bit only_x);
		dphl_pkg::corner_t a, b;
		longint ax, ay, bx, by, dx, cr;
		for (int i = 0; i < 4; i++) begin
			a = corner_tab[slot*4 + i];
			b = corner_tab[slot*4 + (i+1)%4];
			ax = a.x; ay = a.y; bx = b.x; by = b.y;
			if (ax == bx) begin
				if (a.flag ? (x < ax) : (x > ax)) return 1;
			end else if (only_x) begin
				continue;
			end else if (ay == by) begin
				if (a.flag ? (y < ay) : (y > ay)) return 1;
			end else begin
				// products stay below 2^35, exact in 64 bits
				dx = bx - ax;
				cr = (y - ay) * dx - (by - ay) * (x - ax);
				if (dx < 0) cr = -cr;
				if (a.flag ? (cr < 0) : (cr > 0)) return 1;
			end
		end
		return 0;
	endfunction

	function void note_item(dphl_pkg::in_item_t it);
		int cols, rows, slot, found_col, r, c;
		longint x, y, sx, first, last;
		bit hit;
		dphl_pkg::result_t res;
		x = it.coord_x;
		y = it.coord_y;
		if (it.command == dphl_pkg::CMD_LOAD) begin
			slot = int'(it.pad_row) * 128 + int'(it.pad_column);
			corner_tab[slot*4 + it.corner_index] = '{x: it.coord_x, y: it.coord_y,
				flag: it.inside_side};
			written[slot][it.corner_index] = 1'b1;
			active[slot] = it.pad_enable;
			loads++;
			return;
		end
		queries++;
		cols = eff_cols();
		rows = eff_rows();
		sx = split_x;
		if (x < sx) begin
			first = longint'(ref_row) * cols;
			last = split_num;
		end else begin
			first = split_num;
			last = longint'(ref_row) * cols + cols;
		end
		hit = 0;
		found_col = 0;
		// stage one: reference row part
		for (longint n = first; n < last; n++) begin
			r = int'(n / cols);
			c = int'(n % cols);
			if (r >= rows) continue;
			slot = r * 128 + c;
			if (active[slot] && !pad_outside(slot, x, y, 1)) begin
				hit = 1;
				found_col = c;
				break;
			end
		end
		res = '0;
		// stage two: rows of the found column
		if (hit) begin
			for (int j = 0; j < rows; j++) begin
				slot = j * 128 + found_col;
				if (active[slot] && !pad_outside(slot, x, y, 0)) begin
					res.hit_found = 1'b1;
					res.hit_column = 7'(found_col);
					res.hit_row = 7'(j);
					res.hit_pad_number = dphl_pkg::PN_W'(found_col + j * cols);
					hits++;
					break;
				end
			end
		end
		lookups_due.push_back(res);
	endfunction

	function void check_result(dphl_pkg::result_t got);
		dphl_pkg::result_t want;
		if (lookups_due.size() == 0) begin
			$display("%0t: unexpected result %h", $time, got);
			errors++;
			return;
		end
		want = lookups_due.pop_front();
		if (got.hit_found !== want.hit_found) begin
			$display("%0t: hit_found exp %0d act %0d", $time, want.hit_found, got.hit_found);
			errors++;
		end
		if (got.hit_column !== want.hit_column) begin
			$display("%0t: hit_column exp %0d act %0d", $time, want.hit_column,
				got.hit_column);
			errors++;
		end
		if (got.hit_row !== want.hit_row) begin
			$display("%0t: hit_row exp %0d act %0d", $time, want.hit_row, got.hit_row);
			errors++;
		end
		if (got.hit_pad_number !== want.hit_pad_number) begin
			$display("%0t: hit_pad_number exp %0d act %0d", $time, want.hit_pad_number,
				got.hit_pad_number);
			errors++;
		end
	endfunction
endclass

module tb_top;
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	dphl_pkg::in_item_t item = '0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [4:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic busy, done, pready;
	logic [31:0] prdata;
	dphl_pkg::result_t result;

	pad_scoreboard sb;
	int idle_pct;
	int phase_cnt;

	detector_pad_hit_lookup DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .item(item),
		.done(done), .result(result), .psel(psel), .penable(penable),
		.pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
		.pready(pready)
	);

	always #5 clk = ~clk;

	// result monitor
	always @(posedge clk) begin
		if (arst_n && done) sb.check_result(result);
	end

	// hard stop
	initial begin
		#50_000_000;
		$display("Verification failed");
		$finish;
	end

	// one item through start/busy, then maybe a sender gap
	task send_item(dphl_pkg::in_item_t it);
		start <= 1'b1;
		item <= it;
		do @(posedge clk); while (busy);
		sb.note_item(it);
		if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	task reg_write(logic [2:0] idx, logic [31:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		sb.set_reg(idx, val);
	endtask

	// wait for every expected lookup, then let trailing loads settle
	task drain();
		start <= 1'b0;
		do @(posedge clk); while (sb.lookups_due.size() != 0 || busy);
		repeat (40) @(posedge clk);
	endtask

	task query(int x, int y);
		dphl_pkg::in_item_t it;
		it = '0;
		it.command = dphl_pkg::CMD_QUERY;
		it.coord_x = 16'(x);
		it.coord_y = 16'(y);
		send_item(it);
	endtask

	task load_corner(int c, int r, int k, int x, int y, bit flag, bit want_en);
		dphl_pkg::in_item_t it;
		int slot;
		slot = r * 128 + c;
		it.command = dphl_pkg::CMD_LOAD;
		it.pad_column = 7'(c);
		it.pad_row = 7'(r);
		it.corner_index = 2'(k);
		it.coord_x = 16'(x);
		it.coord_y = 16'(y);
		it.inside_side = flag;
		// never activate a pad with a corner still unwritten
		it.pad_enable = want_en && ((sb.written[slot] | (4'b1 << k)) == 4'hf);
		send_item(it);
	endtask

	// grid pad, 200 units square, optionally skewed corners
	task load_pad(int c, int r, int jit, bit want_en);
		int px[4], py[4], dx, dy;
		bit flag;
		px[0] = -12800 + c*200; py[0] = -12800 + r*200;
		px[1] = px[0] + 200;    py[1] = py[0];
		px[2] = px[1];          py[2] = py[0] + 200;
		px[3] = px[0];          py[3] = py[2];
		for (int k = 0; k < 4; k++) begin
			px[k] += $urandom_range(0, 2*jit) - jit;
			py[k] += $urandom_range(0, 2*jit) - jit;
		end
		for (int k = 0; k < 4; k++) begin
			dx = px[(k+1)%4] - px[k];
			dy = py[(k+1)%4] - py[k];
			flag = (dx > 0) || (dx == 0 && dy < 0);
			if ($urandom_range(99) < 8) flag = !flag;
			load_corner(c, r, k, px[k], py[k], flag, want_en);
		end
	endtask

	task extreme_pad(int c, int r);
		load_corner(c, r, 0, -32768, -32768, 1'b1, 1'b1);
		load_corner(c, r, 1, 32767, -32768, 1'b0, 1'b1);
		load_corner(c, r, 2, 32767, 32767, 1'b0, 1'b1);
		load_corner(c, r, 3, -32768, 32767, 1'b1, 1'b1);
	endtask

	task set_grid(int cols, int rows, int rr, int sn, int sx, int idle);
		drain();
		reg_write(dphl_pkg::REG_COLUMNS, 32'(cols));
		reg_write(dphl_pkg::REG_ROWS, 32'(rows));
		reg_write(dphl_pkg::REG_REF_ROW, 32'(rr));
		reg_write(dphl_pkg::REG_SPLIT_N, 32'(sn));
		reg_write(dphl_pkg::REG_SPLIT_X, 32'(sx));
		idle_pct = idle;
		phase_cnt++;
	endtask

	// mix of whole pads, stray corner loads and queries
	task random_items(int n);
		int c, r, kind, span;
		dphl_pkg::in_item_t it;
		span = (sb.eff_cols() < 16) ? sb.eff_cols() : 16;
		for (int i = 0; i < n; i++) begin
			kind = $urandom_range(99);
			if (kind < 20) begin
				load_pad($urandom_range(0, span-1), $urandom_range(0, 15),
					($urandom_range(1) != 0) ? 40 : 0, $urandom_range(99) < 85);
			end else if (kind < 30) begin
				it = dphl_pkg::in_item_t'($bits(dphl_pkg::in_item_t)'({$urandom, $urandom}));
				load_corner(it.pad_column, it.pad_row, it.corner_index, it.coord_x,
					it.coord_y, it.inside_side, it.pad_enable);
			end else if (kind < 80) begin
				c = $urandom_range(0, span-1);
				r = $urandom_range(0, 15);
				query(-12800 + c*200 + $urandom_range(0, 200),
					-12800 + r*200 + $urandom_range(0, 200));
			end else begin
				query($urandom_range(0, 65535) - 32768, $urandom_range(0, 65535) - 32768);
			end
		end
	endtask

	initial begin
		sb = new();
		idle_pct = 0;
		phase_cnt = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		// table clear after reset keeps busy high
		do @(posedge clk); while (busy);

		// directed: empty table, simple pads, skewed pad, full-range pad
		query(0, 0);
		query(-32768, -32768);
		load_pad(64, 0, 0, 1'b1);
		load_pad(64, 2, 0, 1'b1);
		query(100, -12700);
		query(100, -12300);
		query(-1, -12700);
		load_pad(65, 0, 60, 1'b1);
		query(12, -12650);
		extreme_pad(127, 127);
		query(32767, 32767);
		query(-32768, 32767);
		query(0, -32768);

		set_grid(8, 8, 2, 18, 0, 0);
		random_items(90);
		set_grid(16, 12, 5, 85, -1000, 50);
		random_items(90);
		set_grid(1, 128, 127, 127, 32767, 8);
		random_items(40);
		set_grid(0, 255, 0, 0, -32768, 0);
		random_items(40);
		set_grid(255, 0, 0, 0, 0, 50);
		random_items(40);
		// long left scan over the whole table, only a few lookups
		set_grid(128, 128, 0, 16383, 32767, 0);
		query(-12700, -12700);
		query(100, -12300);
		query(32766, 0);
		set_grid(12, 10, 3, 40, -200, 8);
		random_items(100);
		set_grid(8, 16, 0, 0, -12000, 0);
		random_items(80);

		drain();
		repeat (100) @(posedge clk);
		$display("Ran %0d loads and %0d lookups (%0d hits) over %0d register settings.",
			sb.loads, sb.queries, sb.hits, phase_cnt + 1);
		$display("Settings covered grid sizes 0 to 255, both split halves, skewed pads.");
		if (sb.errors == 0 && sb.lookups_due.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end
endmodule
